// File: hw/rtl/sidasc_pkg.sv
// Shared constants and types for the signed integer to decimal text converter.
// Used by sidasc_div10 and signed_int_to_decimal_ascii; no dependencies.
`timescale 1ns / 1ps

package sidasc_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned CharW   = 7;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned QuotW   = 29;   // floor((2^32 - 1) / 10) fits in 29 bits
  localparam int unsigned MaxDigits = 10;
  localparam int unsigned DigIdxW = 4;

  // Reciprocal of ten: floor(x * 0xCCCCCCCD / 2^35) == floor(x / 10) for all 32-bit x
  localparam logic [ValueW-1:0] Recip10     = 32'hCCCC_CCCD;
  localparam int unsigned       Recip10Shift = 35;

  localparam logic [CharW-1:0] ChMinus = 7'd45;
  localparam logic [CharW-1:0] ChZero  = 7'd48;

  localparam logic [DigIdxW-1:0] LastDigIdx = 4'(MaxDigits - 1);

  typedef struct packed {
    logic [QuotW-1:0]  quot;
    logic [DigitW-1:0] rem;
  } div_res_t;

endpackage

// File: hw/rtl/sidasc_div10.sv
// Divide-by-ten unit: quotient by reciprocal multiply, remainder from low bits.
// Depends on sidasc_pkg.
`timescale 1ns / 1ps

module sidasc_div10 (
  input  logic [sidasc_pkg::ValueW-1:0] dividend_i,
  output sidasc_pkg::div_res_t          res_o
);

  logic [2*sidasc_pkg::ValueW-1:0] prod;
  logic [sidasc_pkg::QuotW-1:0]    quot;
  logic [sidasc_pkg::DigitW-1:0]   quot_x10_lo;

  assign prod = {{sidasc_pkg::ValueW{1'b0}}, dividend_i} *
                {{sidasc_pkg::ValueW{1'b0}}, sidasc_pkg::Recip10};
  assign quot = prod[sidasc_pkg::Recip10Shift +: sidasc_pkg::QuotW];

  // Remainder is below ten, so only the low four bits of q*10 matter
  assign quot_x10_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};

  assign res_o.quot = quot;
  assign res_o.rem  = dividend_i[sidasc_pkg::DigitW-1:0] - quot_x10_lo;

endmodule

// File: hw/rtl/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit value in, decimal ASCII characters out, most significant first.
// Depends on sidasc_pkg and sidasc_div10.
`timescale 1ns / 1ps

// Channel  Dir  Width  Contents
// s_axis   in   32     tdata[31:0] = value (two's complement)
// m_axis   out  8      tdata[6:0] = character, tdata[7] = 0, tlast = last
//
// Each item is accepted, then makes d passes through the shared divide-by-ten unit
// (d = digit count, 1..10), then sends one character per cycle into the output register
// while it is free (n = d characters, plus one for a minus sign).
// The longest item is "-2147483648".
// Reset clears the sequencer and the output valid; the digit store needs no reset.
// A stalled output holds its character; input is taken only while the sequencer idles,
// which it may do while the final character still waits to be taken.

module signed_int_to_decimal_ascii (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] character, [7] zero fill
  output logic        m_axis_tlast
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0] state_q, state_d;

  logic [sidasc_pkg::ValueW-1:0]  mag_q, mag_d;
  logic [sidasc_pkg::DigIdxW-1:0] cnt_q, cnt_d;   // digit write index during division
  logic [sidasc_pkg::DigIdxW-1:0] idx_q, idx_d;   // digit read index during emission
  logic                           sign_q, sign_d;
  logic [sidasc_pkg::DigitW-1:0]  digs_q [sidasc_pkg::MaxDigits];

  logic                          out_vld_q, out_vld_d;
  logic [sidasc_pkg::CharW-1:0]  out_ch_q, out_ch_d;
  logic                          out_last_q, out_last_d;

  sidasc_pkg::div_res_t div_res;

  logic in_acc;
  logic out_free;
  logic dig_wr;

  sidasc_div10 u_div10 (
    .dividend_i (mag_q),
    .res_o      (div_res)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign dig_wr        = (state_q == StDiv);

  always_comb begin
    state_d    = state_q;
    mag_d      = mag_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    sign_d     = sign_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_ch_d   = out_ch_q;
    out_last_d = out_last_q;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          // Take the magnitude as unsigned so the most negative value converts too
          sign_d  = s_axis_tdata[sidasc_pkg::ValueW-1];
          mag_d   = s_axis_tdata[sidasc_pkg::ValueW-1] ? (32'd0 - s_axis_tdata)
                                                       : s_axis_tdata;
          cnt_d   = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        // Store one digit per pass, least significant first
        mag_d = {{(sidasc_pkg::ValueW - sidasc_pkg::QuotW){1'b0}}, div_res.quot};
        cnt_d = cnt_q + 4'd1;
        if (div_res.quot == '0 || cnt_q == sidasc_pkg::LastDigIdx) begin
          idx_d   = cnt_q;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          if (sign_q) begin
            // Sign goes ahead of the digits
            out_ch_d   = sidasc_pkg::ChMinus;
            out_last_d = 1'b0;
            sign_d     = 1'b0;
          end else begin
            out_ch_d   = sidasc_pkg::ChZero + {3'b000, digs_q[idx_q]};
            out_last_d = (idx_q == '0);
            idx_d      = idx_q - 4'd1;
            if (idx_q == '0) begin
              state_d = StIdle;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      out_vld_q <= 1'b0;
      sign_q    <= 1'b0;
      cnt_q     <= '0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      sign_q    <= sign_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    out_ch_q   <= out_ch_d;
    out_last_q <= out_last_d;
    if (dig_wr) begin
      digs_q[cnt_q] <= div_res.rem;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_ch_q};
  assign m_axis_tlast  = out_last_q;

  // An accepted item always starts division on the next cycle
  a_acc_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == StDiv))
    else $error("accepted item did not enter division");

  // Read and write indexes stay inside the digit store
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> (idx_q <= sidasc_pkg::LastDigIdx))
    else $error("digit read index out of range");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (cnt_q <= sidasc_pkg::LastDigIdx))
    else $error("digit write index out of range");

  // A minus sign is never the final character
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_ch_q == sidasc_pkg::ChMinus) |-> !out_last_q)
    else $error("minus sign flagged as last");

  // Every other character is a decimal digit
  a_digit_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_ch_q != sidasc_pkg::ChMinus) |->
      (out_ch_q >= sidasc_pkg::ChZero && out_ch_q <= sidasc_pkg::ChZero + 7'd9))
    else $error("character is neither sign nor digit");

endmodule
